// ===== rtl/core/cbm_pkg.sv =====
// ----------------------------------------------------------------------------
// cbm_pkg: shared types and constants of the cartridge bank mapper
// Holds the bus access and result transaction types, the target codes,
// the controller kinds and the banking state passed between the modules.
// ----------------------------------------------------------------------------
package cbm_pkg;

  // Result target codes.
  localparam logic [2:0] TGT_NONE    = 3'd0;
  localparam logic [2:0] TGT_ROM     = 3'd1;
  localparam logic [2:0] TGT_RAM     = 3'd2;
  localparam logic [2:0] TGT_REFUSED = 3'd3;
  localparam logic [2:0] TGT_CONTROL = 3'd4;

  // Controller kinds.
  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_MBC1 = 2'd1;
  localparam logic [1:0] KIND_MBC2 = 2'd2;
  localparam logic [1:0] KIND_MBC3 = 2'd3;

  // Control write regions, taken from address bits 14:13.
  localparam logic [1:0] REG_RAM_ENABLE = 2'd0;
  localparam logic [1:0] REG_ROM_BANK   = 2'd1;
  localparam logic [1:0] REG_UPPER_BANK = 2'd2;
  localparam logic [1:0] REG_MODE       = 2'd3;

  // Access operations.
  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // Value that enables external RAM in the low nibble.
  localparam logic [3:0] RAM_ENABLE_KEY = 4'hA;

  // Configuration register word index.
  localparam logic REG_IDX_KIND = 1'b0;

  typedef struct packed {
    logic        op;
    logic [15:0] address;
    logic [7:0]  write_data;
  } access_t;

  typedef struct packed {
    logic [2:0]  target;
    logic [20:0] phys_address;
    logic        write_enable;
  } result_t;

  // Banking state needed for address translation.
  typedef struct packed {
    logic [6:0] rom_window_bank;
    logic [1:0] ram_bank_select;
    logic       ram_enabled;
  } bank_state_t;

endpackage

// ===== rtl/core/cartridge_bank_mapper.sv =====
// ----------------------------------------------------------------------------
// cartridge_bank_mapper: cartridge memory bank controller
// Translates CPU bus accesses to physical ROM or external RAM addresses and
// keeps the banking registers written through the ROM address range.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake             Payload
//  req       in         req_valid/req_stall   access_t (op, address, write_data)
//  rsp       out        rsp_valid/rsp_stall   result_t (target, phys_address,
//                                             write_enable)
//  cfg       in         APB psel/penable      controller_kind at byte address 0
//
// One transaction is accepted every cycle while req_stall is low. It passes
// through the input register and then the result register, which drives rsp.
// Translation and the banking register update happen in the same cycle, so
// each access sees the effect of every earlier control write.
// A stall on rsp holds the result register; an empty input register still
// takes one transaction, and req_stall rises once it is occupied. Reset clears
// the valid flags and the controller kind and loads the banking registers with
// their reset values; no clearing pass is needed.
// ----------------------------------------------------------------------------
module cartridge_bank_mapper import cbm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  access_t     req,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output result_t     rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic        acc_valid;
  access_t     acc;
  logic [1:0]  kind;
  logic        advance;
  logic        acc_fire;
  logic        acc_load;
  bank_state_t state;
  result_t     res;

  // Configuration port.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_IDX_KIND) ? {30'd0, kind} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      kind <= KIND_NONE;
    end else if (psel && penable && pwrite && paddr[2] == REG_IDX_KIND) begin
      kind <= pwdata[1:0];
    end
  end

  // Pipeline flow control. The input register loads whenever it is empty
  // or its transaction moves on to the result register.
  assign advance   = !rsp_valid || !rsp_stall;
  assign acc_fire  = acc_valid && advance;
  assign acc_load  = advance || !acc_valid;
  assign req_stall = !acc_load;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      acc_valid <= 1'b0;
    end else if (acc_load) begin
      acc_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (acc_load && req_valid) begin
      acc <= req;
    end
  end

  cbm_bank_regs u_bank_regs (
    .clk       (clk),
    .rst       (rst),
    .kind      (kind),
    .wr_en     (acc_fire && acc.op == OP_WRITE && acc.address[15] == 1'b0),
    .wr_region (acc.address[14:13]),
    .wr_data   (acc.write_data),
    .state     (state)
  );

  cbm_translate u_translate (
    .acc   (acc),
    .state (state),
    .res   (res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= acc_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (acc_fire) begin
      rsp <= res;
    end
  end

endmodule

// ===== rtl/core/cbm_bank_regs.sv =====
// ----------------------------------------------------------------------------
// cbm_bank_regs: cartridge banking registers
// Applies control writes below 0x8000 according to the controller kind and
// presents the banking state used for translation.
// ----------------------------------------------------------------------------
module cbm_bank_regs import cbm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic [1:0]  kind,
  input  logic        wr_en,
  input  logic [1:0]  wr_region,
  input  logic [7:0]  wr_data,
  output bank_state_t state
);

  logic [6:0] rom_bank_select;
  logic [6:0] rom_window_bank;
  logic [1:0] ram_bank_select;
  logic       ram_enabled;
  logic       banking_mode;

  logic [6:0] rom_bank_select_next;
  logic [6:0] rom_window_bank_next;
  logic [1:0] ram_bank_select_next;
  logic       ram_enabled_next;
  logic       banking_mode_next;

  logic [4:0] low5;
  logic [3:0] low4;
  logic [6:0] low7;

  // Bank numbers with a zero selection turned into bank one.
  assign low5 = (wr_data[4:0] == 5'd0) ? 5'd1 : wr_data[4:0];
  assign low4 = (wr_data[3:0] == 4'd0) ? 4'd1 : wr_data[3:0];
  assign low7 = (wr_data[6:0] == 7'd0) ? 7'd1 : wr_data[6:0];

  // Next register values for a control write.
  always_comb begin
    rom_bank_select_next = rom_bank_select;
    rom_window_bank_next = rom_window_bank;
    ram_bank_select_next = ram_bank_select;
    ram_enabled_next     = ram_enabled;
    banking_mode_next    = banking_mode;
    if (wr_en && kind != KIND_NONE) begin
      case (wr_region)
        REG_RAM_ENABLE: begin
          ram_enabled_next = (wr_data[3:0] == RAM_ENABLE_KEY);
        end
        REG_ROM_BANK: begin
          case (kind)
            KIND_MBC1: rom_bank_select_next = {rom_bank_select[6:5], low5};
            KIND_MBC2: rom_bank_select_next = {3'd0, low4};
            default:   rom_bank_select_next = low7;
          endcase
          rom_window_bank_next = rom_bank_select_next;
        end
        REG_UPPER_BANK: begin
          if (kind == KIND_MBC3) begin
            if (wr_data[7:2] == 6'd0) begin
              ram_bank_select_next = wr_data[1:0];
            end
          end else if (banking_mode) begin
            ram_bank_select_next = wr_data[1:0];
          end else begin
            rom_bank_select_next = {wr_data[1:0], rom_bank_select[4:0]};
            rom_window_bank_next = rom_bank_select_next;
          end
        end
        default: begin
          if (kind != KIND_MBC3) begin
            banking_mode_next = wr_data[0];
          end
        end
      endcase
    end
  end

  // Banking registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      rom_bank_select <= 7'd0;
      rom_window_bank <= 7'd1;
      ram_bank_select <= 2'd0;
      ram_enabled     <= 1'b0;
      banking_mode    <= 1'b0;
    end else begin
      rom_bank_select <= rom_bank_select_next;
      rom_window_bank <= rom_window_bank_next;
      ram_bank_select <= ram_bank_select_next;
      ram_enabled     <= ram_enabled_next;
      banking_mode    <= banking_mode_next;
    end
  end

  assign state.rom_window_bank = rom_window_bank;
  assign state.ram_bank_select = ram_bank_select;
  assign state.ram_enabled     = ram_enabled;

endmodule

// ===== rtl/core/cbm_translate.sv =====
// ----------------------------------------------------------------------------
// cbm_translate: address decode and translation
// Classifies one bus access and forms the physical ROM or RAM address from
// the current banking state.
// ----------------------------------------------------------------------------
module cbm_translate import cbm_pkg::*; (
  input  access_t     acc,
  input  bank_state_t state,
  output result_t     res
);

  logic is_low;
  logic is_ram;

  assign is_low = (acc.address[15] == 1'b0);
  assign is_ram = (acc.address[15:13] == 3'b101);

  // Decode the region and build the result.
  always_comb begin
    res.target       = TGT_NONE;
    res.phys_address = 21'd0;
    res.write_enable = 1'b0;
    if (is_low) begin
      if (acc.op == OP_WRITE) begin
        res.target = TGT_CONTROL;
      end else if (acc.address[14] == 1'b0) begin
        res.target       = TGT_ROM;
        res.phys_address = {5'd0, acc.address};
      end else begin
        res.target       = TGT_ROM;
        res.phys_address = {state.rom_window_bank, acc.address[13:0]};
      end
    end else if (is_ram) begin
      if (state.ram_enabled) begin
        res.target       = TGT_RAM;
        res.phys_address = {6'd0, state.ram_bank_select, acc.address[12:0]};
        res.write_enable = (acc.op == OP_WRITE);
      end else begin
        res.target = TGT_REFUSED;
      end
    end
  end

endmodule

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: testbench of the cartridge bank mapper
// Sends CPU bus transactions in random bursts with random gaps, stalls the
// result channel on a pattern of its own and compares each result with a
// predictor of the banking registers. The controller kind is written and read
// back over the APB port between phases, while the mapper is idle.
// ----------------------------------------------------------------------------
module tb_top;
  import cbm_pkg::*;

  localparam int unsigned CYCLE_LIMIT      = 200000;
  localparam int unsigned RANDOM_PER_PHASE = 140;
  localparam int unsigned REPORT_MAX       = 10;

  // Predicts the translation of every accepted transaction and holds the
  // expected results in acceptance order.
  class bank_scoreboard;
    logic [1:0]  kind;
    logic [6:0]  rom_bank_sel;
    logic [6:0]  window_bank;
    logic [1:0]  ram_bank_sel;
    logic        ram_on;
    logic        mode;
    result_t     pending_q[$];
    int unsigned errors;

    function new();
      kind         = KIND_NONE;
      rom_bank_sel = '0;
      window_bank  = 7'd1;
      ram_bank_sel = '0;
      ram_on       = 1'b0;
      mode         = 1'b0;
      errors       = 0;
    endfunction

    function void flag(string what, logic [31:0] exp_v, logic [31:0] act_v);
      errors++;
      if (errors <= REPORT_MAX) begin
        $display("mismatch in %s: expected 0x%0h, got 0x%0h", what, exp_v, act_v);
      end
    endfunction

    // Banking register update for a write below 0x8000.
    function void bank_write(logic [15:0] addr, logic [7:0] data);
      logic [6:0] low;
      if (kind == KIND_NONE) return;
      case (addr[14:13])
        REG_RAM_ENABLE: ram_on = (data[3:0] == RAM_ENABLE_KEY);
        REG_ROM_BANK: begin
          case (kind)
            KIND_MBC1: low = {2'b00, data[4:0]};
            KIND_MBC2: low = {3'b000, data[3:0]};
            default:   low = data[6:0];
          endcase
          // A zero bank number selects bank 1 instead.
          if (low == '0) low = 7'd1;
          rom_bank_sel = (kind == KIND_MBC1) ? {rom_bank_sel[6:5], low[4:0]} : low;
          window_bank  = rom_bank_sel;
        end
        REG_UPPER_BANK: begin
          if (kind == KIND_MBC3) begin
            // Selectors of 4 and above address the clock, which is not kept.
            if (data < 8'd4) ram_bank_sel = data[1:0];
          end else if (mode) begin
            ram_bank_sel = data[1:0];
          end else begin
            rom_bank_sel = {data[1:0], rom_bank_sel[4:0]};
            window_bank  = rom_bank_sel;
          end
        end
        default: begin
          if (kind != KIND_MBC3) mode = data[0];
        end
      endcase
    endfunction

    function void note_access(access_t a);
      result_t r;
      r = '0;
      if (!a.address[15]) begin
        if (a.op == OP_WRITE) begin
          bank_write(a.address, a.write_data);
          r.target = TGT_CONTROL;
        end else if (!a.address[14]) begin
          r.target       = TGT_ROM;
          r.phys_address = {5'b0, a.address};
        end else begin
          r.target       = TGT_ROM;
          r.phys_address = {window_bank, a.address[13:0]};
        end
      end else if (a.address[15:13] == 3'b101) begin
        if (ram_on) begin
          r.target       = TGT_RAM;
          r.phys_address = {6'b0, ram_bank_sel, a.address[12:0]};
          r.write_enable = (a.op == OP_WRITE);
        end else begin
          r.target = TGT_REFUSED;
        end
      end
      pending_q.push_back(r);
    endfunction

    function void check_result(result_t r);
      result_t e;
      if (pending_q.size() == 0) begin
        flag("result with none outstanding", '0, 32'(r));
        return;
      end
      e = pending_q.pop_front();
      if (r.target !== e.target) flag("target", 32'(e.target), 32'(r.target));
      if (r.phys_address !== e.phys_address) begin
        flag("phys_address", 32'(e.phys_address), 32'(r.phys_address));
      end
      if (r.write_enable !== e.write_enable) begin
        flag("write_enable", 32'(e.write_enable), 32'(r.write_enable));
      end
    endfunction
  endclass

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_stall;
  access_t     req       = '0;
  logic        rsp_valid;
  logic        rsp_stall = 1'b0;
  result_t     rsp;
  logic        psel      = 1'b0;
  logic        penable   = 1'b0;
  logic        pwrite    = 1'b0;
  logic [2:0]  paddr     = '0;
  logic [31:0] pwdata    = '0;
  logic [31:0] prdata;
  logic        pready;

  bank_scoreboard results_sb = new();
  int unsigned    cycle_count = 0;
  int unsigned    burst_left  = 0;
  int unsigned    stall_left  = 0;

  // Kinds of the purely random phases; the four phases before them come with
  // directed transactions of their own.
  logic [1:0] phase_kinds[$] = '{KIND_NONE, KIND_MBC2, KIND_MBC3, KIND_MBC1,
                                 KIND_NONE, KIND_MBC3, KIND_MBC1};

  cartridge_bank_mapper i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #6 clk = ~clk;

  // Cycle count and run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Result side: check accepted results, then choose the next stall. The
  // pattern steps between none, random, long runs and a fixed period, chosen
  // by bits 9:8 of the cycle count.
  always @(posedge clk) begin
    if (!rst && rsp_valid === 1'b1 && !rsp_stall) results_sb.check_result(rsp);
    if (stall_left != 0) begin
      stall_left--;
      rsp_stall <= 1'b1;
    end else begin
      case (cycle_count[9:8])
        2'd0: rsp_stall <= 1'b0;
        2'd1: rsp_stall <= 1'($urandom_range(0, 1));
        2'd2: begin
          if ($urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 7);
            rsp_stall <= 1'b1;
          end else begin
            rsp_stall <= 1'b0;
          end
        end
        default: rsp_stall <= (cycle_count % 3 == 0);
      endcase
    end
  end

  // One APB transfer on the controller kind register: setup, access, then idle.
  task automatic apb_access(input logic write, input logic [31:0] value,
                            output logic [31:0] rdata);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= {REG_IDX_KIND, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_kind(input logic [1:0] k);
    logic [31:0] rd;
    apb_access(1'b1, {30'b0, k}, rd);
    results_sb.kind = k;
    apb_access(1'b0, '0, rd);
    if (rd !== {30'b0, k}) results_sb.flag("controller_kind read", {30'b0, k}, rd);
  endtask

  // Sends one transaction; a new burst may start after a random gap.
  task automatic send_access(input logic op, input logic [15:0] addr,
                             input logic [7:0] data);
    access_t     a;
    int unsigned gap;
    a.op         = op;
    a.address    = addr;
    a.write_data = data;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        req_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    req_valid <= 1'b1;
    req       <= a;
    do @(posedge clk); while (req_stall !== 1'b0);
    results_sb.note_access(a);
    burst_left--;
  endtask

  // Stops sending and waits until every outstanding result has arrived.
  task automatic drain();
    req_valid <= 1'b0;
    burst_left = 0;
    while (results_sb.pending_q.size() != 0) @(posedge clk);
  endtask

  // Mostly banked and fixed ROM reads, RAM accesses and control writes with content
  // that often enables RAM, plus some outside accesses and pure noise.
  task automatic run_random(input int unsigned count);
    logic        op;
    logic [15:0] addr;
    logic [7:0]  data;
    int unsigned sel;
    repeat (count) begin
      sel  = $urandom_range(0, 99);
      op   = 1'($urandom_range(0, 1));
      addr = 16'($urandom);
      data = 8'($urandom);
      if (sel < 30) begin
        op   = OP_READ;
        addr = {2'b01, addr[13:0]};
      end else if (sel < 38) begin
        op   = OP_READ;
        addr = {2'b00, addr[13:0]};
      end else if (sel < 58) begin
        addr = {3'b101, addr[12:0]};
      end else if (sel < 85) begin
        op   = OP_WRITE;
        addr = {1'b0, addr[14:0]};
        if (addr[14:13] == REG_RAM_ENABLE && $urandom_range(0, 2) != 0) begin
          data[3:0] = RAM_ENABLE_KEY;
        end
        if (addr[14:13] == REG_UPPER_BANK && $urandom_range(0, 1) != 0) begin
          data = 8'($urandom_range(0, 5));
        end
      end else if (sel < 95) begin
        addr = ($urandom_range(0, 1) != 0) ? {3'b100, addr[12:0]} : {2'b11, addr[13:0]};
      end
      send_access(op, addr, data);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // No mapper after reset: control writes are ignored, RAM stays refused.
    send_access(OP_WRITE, 16'h0000, 8'h0A);
    send_access(OP_READ,  16'hA000, 8'h00);
    send_access(OP_READ,  16'h4000, 8'h00);
    drain();

    // MBC1: upper bits with zero low bits first, giving window banks 0 and
    // 0x60, then zero bank, modes, RAM and the region edges.
    set_kind(KIND_MBC1);
    send_access(OP_WRITE, 16'h4000, 8'h00);
    send_access(OP_READ,  16'h4000, 8'h00);
    send_access(OP_WRITE, 16'h5FFF, 8'h03);
    send_access(OP_READ,  16'h7FFF, 8'h00);
    send_access(OP_WRITE, 16'h2000, 8'h00);
    send_access(OP_WRITE, 16'h3FFF, 8'hFF);
    send_access(OP_READ,  16'h0000, 8'hFF);
    send_access(OP_WRITE, 16'h7FFF, 8'h01);
    send_access(OP_WRITE, 16'h4000, 8'h02);
    send_access(OP_WRITE, 16'h1FFF, 8'h0A);
    send_access(OP_WRITE, 16'hA000, 8'hFF);
    send_access(OP_READ,  16'hBFFF, 8'h00);
    send_access(OP_READ,  16'h8000, 8'h00);
    send_access(OP_WRITE, 16'h9FFF, 8'h11);
    send_access(OP_READ,  16'hC000, 8'h00);
    send_access(OP_WRITE, 16'hFFFF, 8'h22);
    run_random(RANDOM_PER_PHASE);
    drain();

    // MBC3: clock selector and latch writes are ignored; full 7-bit bank.
    set_kind(KIND_MBC3);
    send_access(OP_WRITE, 16'h4000, 8'h08);
    send_access(OP_WRITE, 16'h6000, 8'h01);
    send_access(OP_WRITE, 16'h2000, 8'h80);
    send_access(OP_WRITE, 16'h0000, 8'h00);
    send_access(OP_READ,  16'hA000, 8'h00);
    send_access(OP_WRITE, 16'h2000, 8'h7F);
    run_random(RANDOM_PER_PHASE);
    drain();

    // MBC2: only the low nibble selects the bank, zero becoming one.
    set_kind(KIND_MBC2);
    send_access(OP_WRITE, 16'h2000, 8'hF0);
    send_access(OP_READ,  16'h4000, 8'h00);
    run_random(RANDOM_PER_PHASE);

    foreach (phase_kinds[i]) begin
      drain();
      set_kind(phase_kinds[i]);
      run_random(RANDOM_PER_PHASE);
    end

    drain();
    repeat (4) @(posedge clk);
    if (results_sb.errors == 0 && results_sb.pending_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
